// File: design/coo_csr_pkg.sv
// ---------------------------------------------------------------------------
// coo_csr_pkg
// Shared codes, constants and cell handshake types for the sorted
// coordinate-list to compressed-row store.
// ---------------------------------------------------------------------------
package coo_csr_pkg;

  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int KIND_BITS      = 2;
  localparam int STATUS_BITS    = 3;
  localparam int TREE_GROUP     = 32;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_CLEAR     = 2'd0,
    KIND_LOAD      = 2'd1,
    KIND_ROW_QUERY = 2'd2,
    KIND_ENT_QUERY = 2'd3
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 3'd0,
    ST_ROW  = 3'd1,
    ST_COL  = 3'd2,
    ST_FULL = 3'd3,
    ST_POS  = 3'd4
  } status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_NUM_ROWS = 2'd0,
    CFG_NUM_COLS = 2'd1
  } cfg_index_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic commit;
    logic occupied;
    logic tail;
    logic pick;
  } cell_ctrl_t;

  // per-cell compare results
  typedef struct packed {
    logic after;
    logic lt;
  } cell_flags_t;

endpackage

// File: design/coo_csr_cell.sv
// ---------------------------------------------------------------------------
// coo_csr_cell
// One slot of the sorted entry chain: holds a row, column and value, compares
// its key with the incoming key and shifts from its left neighbor on insert.
// ---------------------------------------------------------------------------
module coo_csr_cell
  import coo_csr_pkg::*;
#(
  parameter int INDEX_BITS = 16,
  parameter int VALUE_BITS = 64
) (
  input  logic                             clk,
  input  cell_ctrl_t                       ctrl,
  input  logic [INDEX_BITS-1:0]            ins_row,
  input  logic [INDEX_BITS-1:0]            ins_col,
  input  logic [VALUE_BITS-1:0]            ins_value,
  input  logic                             prev_after,
  input  logic [INDEX_BITS-1:0]            prev_row,
  input  logic [INDEX_BITS-1:0]            prev_col,
  input  logic [VALUE_BITS-1:0]            prev_value,
  output logic [INDEX_BITS-1:0]            row,
  output logic [INDEX_BITS-1:0]            col,
  output logic [VALUE_BITS-1:0]            value,
  output cell_flags_t                      flags,
  output logic [INDEX_BITS+VALUE_BITS-1:0] entry_term
);

  logic key_after;

  assign key_after  = (row != ins_row) ? (row > ins_row) : (col > ins_col);
  assign flags.after = ctrl.occupied && key_after;
  assign flags.lt    = ctrl.occupied && (row < ins_row);
  assign entry_term  = ctrl.pick ? {col, value} : '0;

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      if (prev_after) begin
        row   <= prev_row;
        col   <= prev_col;
        value <= prev_value;
      end else if (flags.after || ctrl.tail) begin
        row   <= ins_row;
        col   <= ins_col;
        value <= ins_value;
      end
    end
  end

endmodule

// File: design/coo_csr_or_tree.sv
// ---------------------------------------------------------------------------
// coo_csr_or_tree
// Two-level OR reduction over the cell terms: groups are reduced and
// registered, the group results are combined combinationally.
// ---------------------------------------------------------------------------
module coo_csr_or_tree
  import coo_csr_pkg::*;
#(
  parameter int N = 1024,
  parameter int W = 11
) (
  input  logic           clk,
  input  logic [N*W-1:0] terms,
  output logic [W-1:0]   result
);

  localparam int NG = (N + TREE_GROUP - 1) / TREE_GROUP;

  logic [W-1:0] grp [NG];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic [W-1:0] part [TREE_GROUP];
    logic [W-1:0] acc;

    for (genvar k = 0; k < TREE_GROUP; k++) begin : g_part
      if (g * TREE_GROUP + k < N) begin : g_used
        assign part[k] = terms[(g*TREE_GROUP+k)*W +: W];
      end else begin : g_pad
        assign part[k] = '0;
      end
    end

    always_comb begin
      acc = '0;
      for (int k = 0; k < TREE_GROUP; k++) begin
        acc = acc | part[k];
      end
    end

    always_ff @(posedge clk) begin
      grp[g] <= acc;
    end
  end

  always_comb begin
    result = '0;
    for (int g = 0; g < NG; g++) begin
      result = result | grp[g];
    end
  end

endmodule

// File: design/coo_to_csr_sorted_store.sv
// ---------------------------------------------------------------------------
// coo_to_csr_sorted_store
// Sorted entry store that turns coordinate-list entries into compressed
// sparse row answers.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on the result ports for exactly one cycle with done high, and the
// receiver cannot stall it. Clear and load results are registered from the
// execute state; row-offset and entry queries add the reduce state for the
// registered group stage of the OR reduction over the row of cells. A load is
// inserted into every cell at once, each cell either keeping its entry,
// taking its left neighbor's or taking the new one. A new item may be started
// in the cycle its predecessor's result is shown. There is no clearing pass
// after reset. The configuration channel is always ready; the user must write
// it only while the block is idle, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module coo_to_csr_sorted_store
  import coo_csr_pkg::*;
#(
  parameter int ENTRY_DEPTH = 1024,
  parameter int INDEX_BITS  = 16,
  parameter int VALUE_BITS  = 64,
  localparam int POS_BITS   = (ENTRY_DEPTH > 2) ? $clog2(ENTRY_DEPTH) : 1,
  localparam int COUNT_BITS = $clog2(ENTRY_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [KIND_BITS-1:0]      kind,
  input  logic [INDEX_BITS-1:0]     row,
  input  logic [INDEX_BITS-1:0]     col,
  input  logic [VALUE_BITS-1:0]     value,
  input  logic [POS_BITS-1:0]       position,
  output logic                      done,
  output logic [STATUS_BITS-1:0]    status,
  output logic [COUNT_BITS-1:0]     offset,
  output logic [INDEX_BITS-1:0]     entry_col,
  output logic [VALUE_BITS-1:0]     entry_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  localparam int CMP_BITS   = (INDEX_BITS > CFG_BITS) ? INDEX_BITS : CFG_BITS;
  localparam int ENTRY_BITS = INDEX_BITS + VALUE_BITS;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_REDUCE = 3'b100
  } state_t;

  state_t                  state, state_next;
  logic [CFG_BITS-1:0]     num_rows;
  logic [CFG_BITS-1:0]     num_cols;
  logic [COUNT_BITS-1:0]   entry_count;
  kind_t                   item_kind;
  logic [INDEX_BITS-1:0]   item_row;
  logic [INDEX_BITS-1:0]   item_col;
  logic [VALUE_BITS-1:0]   item_value;
  logic [POS_BITS-1:0]     item_pos;
  status_t                 item_status;
  status_t                 exec_status;
  logic                    commit;

  logic [INDEX_BITS-1:0]   cell_row   [ENTRY_DEPTH];
  logic [INDEX_BITS-1:0]   cell_col   [ENTRY_DEPTH];
  logic [VALUE_BITS-1:0]   cell_value [ENTRY_DEPTH];
  cell_flags_t             cell_flags [ENTRY_DEPTH];
  cell_ctrl_t              cell_ctrl  [ENTRY_DEPTH];

  logic [ENTRY_DEPTH*COUNT_BITS-1:0] off_terms;
  logic [ENTRY_DEPTH*ENTRY_BITS-1:0] ent_terms;
  logic [COUNT_BITS-1:0]             off_result;
  logic [ENTRY_BITS-1:0]             ent_result;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= CFG_BITS'(1);
      num_cols <= CFG_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_ROWS: num_rows <= cfg_data;
        CFG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_kind  <= kind_t'(kind);
      item_row   <= row;
      item_col   <= col;
      item_value <= value;
      item_pos   <= position;
    end
    if (state == S_EXEC) begin
      item_status <= exec_status;
    end
  end

  always_comb begin
    exec_status = ST_OK;
    case (item_kind)
      KIND_CLEAR: exec_status = ST_OK;
      KIND_LOAD: begin
        if (CMP_BITS'(item_row) >= CMP_BITS'(num_rows)) begin
          exec_status = ST_ROW;
        end else if (CMP_BITS'(item_col) >= CMP_BITS'(num_cols)) begin
          exec_status = ST_COL;
        end else if (entry_count == COUNT_BITS'(ENTRY_DEPTH)) begin
          exec_status = ST_FULL;
        end
      end
      KIND_ROW_QUERY: begin
        if (CMP_BITS'(item_row) > CMP_BITS'(num_rows)) begin
          exec_status = ST_ROW;
        end
      end
      KIND_ENT_QUERY: begin
        if (COUNT_BITS'(item_pos) >= entry_count) begin
          exec_status = ST_POS;
        end
      end
      default: exec_status = ST_OK;
    endcase
  end

  assign commit = (state == S_EXEC) && (item_kind == KIND_LOAD) && (exec_status == ST_OK);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_kind == KIND_CLEAR || item_kind == KIND_LOAD) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_EXEC && item_kind == KIND_CLEAR) begin
        entry_count <= '0;
      end else if (commit) begin
        entry_count <= entry_count + COUNT_BITS'(1);
      end
      if (state == S_EXEC && (item_kind == KIND_CLEAR || item_kind == KIND_LOAD)) begin
        done <= 1'b1;
      end else if (state == S_REDUCE) begin
        done <= 1'b1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == S_EXEC && (item_kind == KIND_CLEAR || item_kind == KIND_LOAD)) begin
      status      <= exec_status;
      offset      <= '0;
      entry_col   <= '0;
      entry_value <= '0;
    end else if (state == S_REDUCE) begin
      status      <= item_status;
      offset      <= '0;
      entry_col   <= '0;
      entry_value <= '0;
      if (item_status == ST_OK && item_kind == KIND_ROW_QUERY) begin
        offset <= off_result;
      end
      if (item_status == ST_OK && item_kind == KIND_ENT_QUERY) begin
        entry_col   <= ent_result[ENTRY_BITS-1:VALUE_BITS];
        entry_value <= ent_result[VALUE_BITS-1:0];
      end
    end
  end

  // cell chain
  for (genvar i = 0; i < ENTRY_DEPTH; i++) begin : g_cell
    logic                  prev_after;
    logic [INDEX_BITS-1:0] prev_row;
    logic [INDEX_BITS-1:0] prev_col;
    logic [VALUE_BITS-1:0] prev_value;
    logic                  next_lt;

    if (i == 0) begin : g_head
      assign prev_after = 1'b0;
      assign prev_row   = '0;
      assign prev_col   = '0;
      assign prev_value = '0;
    end else begin : g_link
      assign prev_after = cell_flags[i-1].after;
      assign prev_row   = cell_row[i-1];
      assign prev_col   = cell_col[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == ENTRY_DEPTH - 1) begin : g_last
      assign next_lt = 1'b0;
    end else begin : g_mid
      assign next_lt = cell_flags[i+1].lt;
    end

    assign cell_ctrl[i].commit   = commit;
    assign cell_ctrl[i].occupied = (COUNT_BITS'(i) < entry_count);
    assign cell_ctrl[i].tail     = (COUNT_BITS'(i) == entry_count);
    assign cell_ctrl[i].pick     = (COUNT_BITS'(item_pos) == COUNT_BITS'(i));

    assign off_terms[i*COUNT_BITS +: COUNT_BITS] =
      (cell_flags[i].lt && !next_lt) ? COUNT_BITS'(i + 1) : '0;

    coo_csr_cell #(
      .INDEX_BITS (INDEX_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .ins_row    (item_row),
      .ins_col    (item_col),
      .ins_value  (item_value),
      .prev_after (prev_after),
      .prev_row   (prev_row),
      .prev_col   (prev_col),
      .prev_value (prev_value),
      .row        (cell_row[i]),
      .col        (cell_col[i]),
      .value      (cell_value[i]),
      .flags      (cell_flags[i]),
      .entry_term (ent_terms[i*ENTRY_BITS +: ENTRY_BITS])
    );
  end

  coo_csr_or_tree #(
    .N (ENTRY_DEPTH),
    .W (COUNT_BITS)
  ) u_off_tree (
    .clk    (clk),
    .terms  (off_terms),
    .result (off_result)
  );

  coo_csr_or_tree #(
    .N (ENTRY_DEPTH),
    .W (ENTRY_BITS)
  ) u_ent_tree (
    .clk    (clk),
    .terms  (ent_terms),
    .result (ent_result)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_BITS'(ENTRY_DEPTH))
    else $error("entry count above depth");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in flight");

  a_commit_count: assert property (@(posedge clk) disable iff (rst)
    commit |=> entry_count == $past(entry_count) + COUNT_BITS'(1))
    else $error("insert did not grow the store");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer did not start work");

  a_busy_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("item finished without a result");
`endif

endmodule
